/* hw/rtl/row_symmetric_int8_quantizer_core_macros.svh */
// assertion macros for the quantizer core
`ifndef ROW_SYMMETRIC_INT8_QUANTIZER_CORE_MACROS_SVH
`define ROW_SYMMETRIC_INT8_QUANTIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define RSQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rsq assertion failed");
`define RSQ_ASSERT_NEVER(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("rsq forbidden condition seen");
`else
`define RSQ_ASSERT(label, clk, rst_n, prop)
`define RSQ_ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

/* hw/rtl/rsq_pkg.sv */
package rsq_pkg;

    localparam int QDEPTH    = 2;
    localparam int QIDX_W    = 1;
    localparam int QCNT_W    = 2;
    localparam int DIVSTEPS  = 25;

    localparam logic FUNC_SCAN  = 1'b0;
    localparam logic FUNC_QUANT = 1'b1;
    localparam logic FMT_F32    = 1'b0;
    localparam logic FMT_F16    = 1'b1;
    localparam logic KIND_SCALE = 1'b0;
    localparam logic KIND_QUANT = 1'b1;
    localparam logic DSEL_SCALE = 1'b0;
    localparam logic DSEL_INV   = 1'b1;

    localparam logic [31:0] F32_ONE = 32'h3F80_0000;
    localparam logic [31:0] F16_ONE = 32'h0000_3C00;
    localparam logic [31:0] F32_127 = 32'h42FE_0000;
    localparam logic [31:0] F32_INF = 32'h7F80_0000;
    localparam logic [23:0] MANT_127 = 24'hFE_0000;
    localparam logic signed [9:0] EXP_127 = 10'sd6;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_FINITE,
        CLS_INF,
        CLS_NAN
    } t_cls;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_QRND,
        S_DIV,
        S_DRND,
        S_SOUT
    } t_state;

    typedef struct packed {
        logic        func;
        logic [31:0] element;
        logic        last_in_row;
    } t_req;

    typedef struct packed {
        logic              result_kind;
        logic [31:0]       scale_bits;
        logic signed [7:0] quantized;
        logic              row_done;
    } t_rsp;

    typedef struct packed {
        logic              func;
        logic              last;
        logic              fmt;
        logic              sign;
        t_cls              cls;
        logic [30:0]       mag;
        logic [23:0]       mant;
        logic signed [9:0] expo;
    } t_entry;

endpackage

/* hw/rtl/rsq_front.sv */
module rsq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_ready,
    input  rsq_pkg::t_req i_req,
    input  logic          i_full,
    output logic          o_push,
    output rsq_pkg::t_entry o_entry
);
    import rsq_pkg::*;

    logic        r_fmt;
    logic [31:0] w_eb;
    logic [7:0]  w_ex;
    logic [22:0] w_man;
    logic [4:0]  w_p;

    function automatic logic [31:0] f16_widen(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [32:0] sh;
        logic [31:0] r;
        ex  = h[14:10];
        man = h[9:0];
        p   = '0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) begin
                p = 4'(i);
            end
        end
        sh = 33'(man) << (5'd23 - 5'(p));
        if (ex == 5'h1F) begin
            r = {h[15], 8'hFF, man, 13'b0};
        end else if (ex != 5'd0) begin
            r = {h[15], 8'(ex) + 8'd112, man, 13'b0};
        end else if (man == 10'd0) begin
            r = {h[15], 31'b0};
        end else begin
            r = {h[15], 8'd103 + 8'(p), sh[22:0]};
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_F32;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    assign w_eb  = (r_fmt == FMT_F16) ? f16_widen(i_req.element[15:0]) : i_req.element;
    assign w_ex  = w_eb[30:23];
    assign w_man = w_eb[22:0];

    // subnormal leading one
    always_comb begin
        w_p = '0;
        for (int i = 0; i < 23; i++) begin
            if (w_man[i]) begin
                w_p = 5'(i);
            end
        end
    end

    always_comb begin
        o_entry.func = i_req.func;
        o_entry.last = i_req.last_in_row;
        o_entry.fmt  = r_fmt;
        o_entry.sign = w_eb[31];
        o_entry.mag  = w_eb[30:0];
        o_entry.mant = {1'b1, w_man};
        o_entry.expo = $signed({2'b00, w_ex}) - 10'sd127;
        if (w_ex == 8'hFF) begin
            o_entry.cls = (w_man == '0) ? CLS_INF : CLS_NAN;
        end else if (w_ex != 8'd0) begin
            o_entry.cls = CLS_FINITE;
        end else if (w_man == '0) begin
            o_entry.cls = CLS_ZERO;
        end else begin
            o_entry.cls  = CLS_FINITE;
            o_entry.mant = 24'({1'b0, w_man} << (5'd23 - w_p));
            o_entry.expo = $signed({5'b00000, w_p}) - 10'sd149;
        end
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

/* hw/rtl/rsq_queue.sv */
module rsq_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rsq_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_valid,
    output rsq_pkg::t_entry o_head,
    input  logic            i_pop
);
    import rsq_pkg::*;

    t_entry              r_mem [QDEPTH];
    logic [QIDX_W-1:0]   r_wp;
    logic [QIDX_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QIDX_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QIDX_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10: begin
                    r_cnt <= r_cnt + QCNT_W'(1);
                end
                2'b01: begin
                    r_cnt <= r_cnt - QCNT_W'(1);
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

endmodule

/* hw/rtl/rsq_back.sv */
`include "row_symmetric_int8_quantizer_core_macros.svh"
module rsq_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  rsq_pkg::t_entry i_q_head,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output rsq_pkg::t_rsp   o_rsp
);
    import rsq_pkg::*;

    typedef struct packed {
        logic pop;
        logic take;
        logic scan_upd;
        logic clr_max;
        logic emit_one;
        logic emit_quant;
        logic emit_scale;
        logic div_start;
        logic div_step;
        logic div_round;
        logic mul;
    } t_ctl;

    t_state            r_state, n_state;
    t_ctl              w_ctl;
    t_entry            r_cur;
    logic [30:0]       r_max;
    logic [23:0]       r_max_m;
    logic signed [9:0] r_max_e;
    logic [23:0]       r_rng_m;
    logic signed [9:0] r_rng_e;
    logic [31:0]       r_inv;
    logic [47:0]       r_prod;
    logic signed [10:0] r_pexp;
    logic              r_qzero, r_qsat, r_qsign;
    logic [25:0]       r_rem;
    logic [23:0]       r_den;
    logic [24:0]       r_quo;
    logic signed [9:0] r_dexp;
    logic [4:0]        r_dcnt;
    logic              r_dsel;
    logic [31:0]       r_res;
    logic              r_fmt;
    logic              r_ov;
    t_rsp              r_out;

    logic              w_busy, w_emit;
    logic              w_upd;
    logic [30:0]       w_nmax;
    logic [23:0]       w_nm;
    logic signed [9:0] w_ne;
    logic [23:0]       w_dnum, w_dden;
    logic signed [9:0] w_dexp;
    logic              w_dlt;
    logic              w_ge;
    logic [25:0]       w_rsub;
    logic [23:0]       w_inv_m;
    logic signed [9:0] w_inv_e;
    logic              w_inv_inf;
    logic [47:0]       w_prod;
    // quantize rounding
    logic              w_top;
    logic [47:0]       w_pm;
    logic signed [10:0] w_pe;
    logic [24:0]       w_m25;
    logic [4:0]        w_qsh;
    logic [25:0]       w_qt;
    logic [6:0]        w_qmag;
    logic [7:0]        w_qmag8;
    logic [7:0]        w_qval;
    // divider rounding
    logic signed [9:0] w_be, w_bt;
    logic [4:0]        w_bsh;
    logic [50:0]       w_wide;
    logic [24:0]       w_bn, w_bnr;
    logic              w_bg, w_bst;
    logic [7:0]        w_bbase;
    logic [31:0]       w_dbits;

    function automatic logic [31:0] f32_to_f16(input logic [31:0] f);
        logic [7:0]  ex;
        logic [22:0] man;
        logic [18:0] q;
        logic [12:0] rem;
        logic [7:0]  sh8;
        logic [4:0]  sh;
        logic [23:0] mfull, qs, rs, hw;
        logic [31:0] r;
        ex    = f[30:23];
        man   = f[22:0];
        q     = {1'b0, ex - 8'd112, man[22:13]};
        rem   = man[12:0];
        sh8   = 8'd126 - ex;
        sh    = sh8[4:0];
        mfull = {1'b1, man};
        qs    = mfull >> sh;
        rs    = mfull & ((24'd1 << sh) - 24'd1);
        hw    = 24'd1 << (sh - 5'd1);
        r     = '0;
        if (ex >= 8'd113) begin
            if (rem > 13'h1000 || (rem == 13'h1000 && q[0])) begin
                q = q + 19'd1;
            end
            r = {17'b0, q[14:0]};
        end else if (ex != 8'd0 && sh8 <= 8'd25) begin
            if (rs > hw || (rs == hw && qs[0])) begin
                qs = qs + 24'd1;
            end
            r = {8'b0, qs};
        end
        return r;
    endfunction

    assign w_busy = r_ov && !i_ready;
    assign w_emit = w_ctl.emit_one || w_ctl.emit_quant || w_ctl.emit_scale;

    // running maximum
    assign w_upd  = (i_q_head.cls == CLS_ZERO || i_q_head.cls == CLS_FINITE)
                    && (i_q_head.mag > r_max);
    assign w_nmax = w_upd ? i_q_head.mag : r_max;
    assign w_nm   = w_upd ? i_q_head.mant : r_max_m;
    assign w_ne   = w_upd ? i_q_head.expo : r_max_e;

    always_comb begin
        if (r_state == S_IDLE) begin
            w_dnum = w_nm;
            w_dden = MANT_127;
            w_dexp = w_ne - EXP_127;
        end else begin
            w_dnum = MANT_127;
            w_dden = r_rng_m;
            w_dexp = EXP_127 - r_rng_e;
        end
    end
    assign w_dlt  = w_dnum < w_dden;
    assign w_ge   = r_rem >= {2'b00, r_den};
    assign w_rsub = w_ge ? (r_rem - {2'b00, r_den}) : r_rem;

    assign w_inv_m   = {1'b1, r_inv[22:0]};
    assign w_inv_e   = $signed({2'b00, r_inv[30:23]}) - 10'sd127;
    assign w_inv_inf = (r_inv[30:23] == 8'hFF);
    assign w_prod    = r_cur.mant * w_inv_m;

    // product to float, then half away from zero
    always_comb begin
        w_top   = r_prod[47];
        w_pm    = w_top ? r_prod : {r_prod[46:0], 1'b0};
        w_pe    = r_pexp + (w_top ? 11'sd1 : 11'sd0);
        w_m25   = {1'b0, w_pm[47:24]} + 25'(w_pm[23] && ((|w_pm[22:0]) || w_pm[24]));
        w_qsh   = 5'(11'sd23 - w_pe);
        w_qt    = ({1'b0, w_m25} + (26'd1 << (w_qsh - 5'd1))) >> w_qsh;
        if (r_qzero) begin
            w_qmag = 7'd0;
        end else if (r_qsat || w_pe >= 11'sd7) begin
            w_qmag = 7'd127;
        end else if (w_pe < -11'sd2) begin
            w_qmag = 7'd0;
        end else if (w_qt >= 26'd127) begin
            w_qmag = 7'd127;
        end else begin
            w_qmag = w_qt[6:0];
        end
        w_qmag8 = {1'b0, w_qmag};
        w_qval  = r_qsign ? (8'd0 - w_qmag8) : w_qmag8;
    end

    // quotient to binary32, subnormal and overflow included
    always_comb begin
        w_be = r_dexp + 10'sd127;
        w_bt = 10'sd2 - w_be;
        if (w_be >= 10'sd1) begin
            w_bsh = 5'd1;
        end else if (w_bt > 10'sd26) begin
            w_bsh = 5'd26;
        end else begin
            w_bsh = 5'(w_bt);
        end
        w_wide  = {r_quo, 26'b0} >> w_bsh;
        w_bn    = w_wide[50:26];
        w_bg    = w_wide[25];
        w_bst   = (|w_wide[24:0]) || (r_rem != '0);
        w_bnr   = w_bn + 25'(w_bg && (w_bst || w_bn[0]));
        w_bbase = (w_be >= 10'sd1) ? 8'(w_be - 10'sd1) : 8'd0;
        w_dbits = (w_be >= 10'sd255) ? F32_INF : ({1'b0, w_bbase, 23'b0} + {7'b0, w_bnr});
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_head.func == FUNC_QUANT) begin
                    n_state = S_MUL;
                end else if (i_q_valid && i_q_head.last && w_nmax != '0) begin
                    n_state = S_DIV;
                end
            end
            S_MUL: begin
                n_state = S_QRND;
            end
            S_QRND: begin
                if (!w_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (r_dcnt == 5'(DIVSTEPS - 1)) begin
                    n_state = S_DRND;
                end
            end
            S_DRND: begin
                n_state = (r_dsel == DSEL_SCALE) ? S_SOUT : S_IDLE;
            end
            S_SOUT: begin
                if (!w_busy) begin
                    n_state = S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    priority if (i_q_head.func == FUNC_QUANT) begin
                        w_ctl.pop  = 1'b1;
                        w_ctl.take = 1'b1;
                    end else if (!i_q_head.last) begin
                        w_ctl.pop      = 1'b1;
                        w_ctl.scan_upd = 1'b1;
                    end else if (w_nmax == '0) begin
                        if (!w_busy) begin
                            w_ctl.pop      = 1'b1;
                            w_ctl.clr_max  = 1'b1;
                            w_ctl.emit_one = 1'b1;
                        end
                    end else begin
                        w_ctl.pop       = 1'b1;
                        w_ctl.clr_max   = 1'b1;
                        w_ctl.div_start = 1'b1;
                    end
                end
            end
            S_MUL: begin
                w_ctl.mul = 1'b1;
            end
            S_QRND: begin
                w_ctl.emit_quant = !w_busy;
            end
            S_DIV: begin
                w_ctl.div_step = 1'b1;
            end
            S_DRND: begin
                w_ctl.div_round = 1'b1;
            end
            S_SOUT: begin
                w_ctl.emit_scale = !w_busy;
                w_ctl.div_start  = !w_busy;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max   <= '0;
            r_inv   <= F32_127;
            r_dcnt  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.clr_max) begin
                r_max <= '0;
            end else if (w_ctl.scan_upd) begin
                r_max <= w_nmax;
            end
            if (w_ctl.emit_one) begin
                r_inv <= F32_127;
            end else if (w_ctl.div_round && r_dsel == DSEL_INV) begin
                r_inv <= w_dbits;
            end
            if (w_ctl.div_start) begin
                r_dcnt <= '0;
            end else if (w_ctl.div_step) begin
                r_dcnt <= r_dcnt + 5'd1;
            end
            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.take) begin
            r_cur <= i_q_head;
        end
        if (w_ctl.scan_upd) begin
            r_max_m <= w_nm;
            r_max_e <= w_ne;
        end
        if (w_ctl.div_start && r_state == S_IDLE) begin
            r_rng_m <= w_nm;
            r_rng_e <= w_ne;
            r_fmt   <= i_q_head.fmt;
        end
        if (w_ctl.div_start) begin
            r_rem  <= w_dlt ? {1'b0, w_dnum, 1'b0} : {2'b00, w_dnum};
            r_den  <= w_dden;
            r_dexp <= w_dlt ? (w_dexp - 10'sd1) : w_dexp;
            r_quo  <= '0;
            r_dsel <= (r_state == S_IDLE) ? DSEL_SCALE : DSEL_INV;
        end else if (w_ctl.div_step) begin
            r_rem <= {w_rsub[24:0], 1'b0};
            r_quo <= {r_quo[23:0], w_ge};
        end
        if (w_ctl.div_round) begin
            r_res <= w_dbits;
        end
        if (w_ctl.mul) begin
            r_prod  <= w_prod;
            r_pexp  <= 11'(r_cur.expo) + 11'(w_inv_e);
            r_qzero <= (r_cur.cls == CLS_NAN) || (r_cur.cls == CLS_ZERO);
            r_qsat  <= (r_cur.cls == CLS_INF) || (r_cur.cls == CLS_FINITE && w_inv_inf);
            r_qsign <= r_cur.sign;
        end
        if (w_ctl.emit_one) begin
            r_out.result_kind <= KIND_SCALE;
            r_out.scale_bits  <= (i_q_head.fmt == FMT_F16) ? F16_ONE : F32_ONE;
            r_out.quantized   <= '0;
            r_out.row_done    <= 1'b1;
        end else if (w_ctl.emit_quant) begin
            r_out.result_kind <= KIND_QUANT;
            r_out.scale_bits  <= '0;
            r_out.quantized   <= w_qval;
            r_out.row_done    <= r_cur.last;
        end else if (w_ctl.emit_scale) begin
            r_out.result_kind <= KIND_SCALE;
            r_out.scale_bits  <= (r_fmt == FMT_F16) ? f32_to_f16(r_res) : r_res;
            r_out.quantized   <= '0;
            r_out.row_done    <= 1'b1;
        end
    end

    assign o_q_pop = w_ctl.pop;
    assign o_valid = r_ov;
    assign o_rsp   = r_out;

    `RSQ_ASSERT(a_pop_idle, i_clk, i_rst_n, o_q_pop |-> (r_state == S_IDLE))
    `RSQ_ASSERT_NEVER(a_emit_busy, i_clk, i_rst_n, w_emit && w_busy)
    `RSQ_ASSERT(a_quo_norm, i_clk, i_rst_n, (r_state == S_DRND) |-> r_quo[24])
    `RSQ_ASSERT_NEVER(a_inv_neg, i_clk, i_rst_n, r_inv[31])

endmodule

/* hw/rtl/row_symmetric_int8_quantizer_core.sv */
// channel   dir  handshake            payload
// request   in   i_valid / o_ready    i_req  (func, element, last_in_row)
// result    out  o_valid / i_ready    o_rsp  (result_kind, scale_bits, quantized, row_done)
// config    in   i_cfg_we             i_cfg_wdata (elem_format)
//
// scan request not marked last: folded into the running maximum without leaving idle
// quantize request: goes through the 24x24 mantissa multiply and then the rounding stage
// row end with a nonzero maximum: two 25-step restoring divisions on one shared divider
// requests queue up to 2 deep while the back end is busy; the result register
// holds a result until taken and stalls only the next emitting step
// reset is synchronous: max cleared, inverse scale 127.0, format binary32
module row_symmetric_int8_quantizer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata,
    input  logic          i_valid,
    output logic          o_ready,
    input  rsq_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output rsq_pkg::t_rsp o_rsp
);
    import rsq_pkg::*;

    logic   w_push, w_full, w_qv, w_pop;
    t_entry w_entry, w_head;

    rsq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req      (i_req),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_entry    (w_entry)
    );

    rsq_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_entry(w_entry),
        .o_full (w_full),
        .o_valid(w_qv),
        .o_head (w_head),
        .i_pop  (w_pop)
    );

    rsq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_qv),
        .i_q_head (w_head),
        .o_q_pop  (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_rsp    (o_rsp)
    );

endmodule
